>>> src/lstn_pkg.sv
// Shared types and constants for the lidar scan time normalizer.
// No dependencies; imported by lstn_finish, the top level and the bench.
package lstn_pkg;

	localparam int TS_W   = 64;
	localparam int NS_W   = 63;
	localparam int DUR_W  = 32;
	localparam int OFF_W  = 48;
	localparam int MODE_W = 2;
	localparam int IDX_W  = 2;
	localparam int DATA_W = 48;
	localparam int SUM_W  = 65;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_MAX_DURATION      = 2'd0;
	localparam logic [IDX_W-1:0] REG_EXPECTED_DURATION = 2'd1;
	localparam logic [IDX_W-1:0] REG_ANCHOR_MODE       = 2'd2;
	localparam logic [IDX_W-1:0] REG_STATIC_OFFSET     = 2'd3;

	// Anchor positions; the unused code behaves as scan end
	localparam logic [MODE_W-1:0] ANCHOR_BEGIN = 2'd0;
	localparam logic [MODE_W-1:0] ANCHOR_MID   = 2'd1;
	localparam logic [MODE_W-1:0] ANCHOR_END   = 2'd2;

	localparam logic [DUR_W-1:0]  MAX_DURATION_RST = 32'd200000000;
	localparam logic [DUR_W-1:0]  EXP_DURATION_RST = 32'd100000000;
	localparam logic [MODE_W-1:0] ANCHOR_MODE_RST  = ANCHOR_END;
	localparam logic [OFF_W-1:0]  OFFSET_RST       = 48'd0;

	// Largest positive signed 64-bit time, as a 65-bit signed value
	localparam logic signed [SUM_W-1:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [DUR_W-1:0]  max_duration;
		logic [DUR_W-1:0]  expected_duration;
		logic [MODE_W-1:0] anchor_mode;
		logic [OFF_W-1:0]  static_offset;
	} cfg_t;

	typedef struct packed {
		logic [NS_W-1:0] earliest;
		logic [NS_W-1:0] latest;
		logic            latest_valid;
		logic            all_stamped;
		logic [NS_W-1:0] meas;
	} scan_sum_t;

	typedef struct packed {
		logic            ok;
		logic [NS_W-1:0] span_start;
		logic [NS_W-1:0] span_stop;
		logic            quality;
		logic            all_stamped;
	} result_t;

endpackage

>>> src/lidar_scan_time_normalizer_unit.sv
// A last item gives its result word on out_valid once it has passed stages 1 to 4 and the output register.
// Throughput: one item per cycle while nothing stalls; items that are not last give no result.
// The input register, the three interval stages and the output register each hold one word,
// and a stalled output holds back only as far as the first empty stage.
// Reset clears every valid, returns the scan accumulators to their empty state and loads
// the configuration registers with their default values.
module lidar_scan_time_normalizer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        wr_en,
	input  logic [lstn_pkg::IDX_W-1:0]  wr_index,
	input  logic [lstn_pkg::DATA_W-1:0] wr_data,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lstn_pkg::TS_W-1:0]   point_timestamp,
	input  logic                        has_point,
	input  logic [lstn_pkg::NS_W-1:0]   meas_time,
	input  logic                        last,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [lstn_pkg::NS_W-1:0]   span_start,
	output logic [lstn_pkg::NS_W-1:0]   span_stop,
	output logic                        quality,
	output logic                        all_stamped
);
	import lstn_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_duration      <= MAX_DURATION_RST;
			cfg_q.expected_duration <= EXP_DURATION_RST;
			cfg_q.anchor_mode       <= ANCHOR_MODE_RST;
			cfg_q.static_offset     <= OFFSET_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_DURATION:      cfg_q.max_duration      <= wr_data[DUR_W-1:0];
				REG_EXPECTED_DURATION: cfg_q.expected_duration <= wr_data[DUR_W-1:0];
				REG_ANCHOR_MODE:       cfg_q.anchor_mode       <= wr_data[MODE_W-1:0];
				REG_STATIC_OFFSET:     cfg_q.static_offset     <= wr_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic            valid_s1;
	logic [TS_W-1:0] ts_s1;
	logic            has_s1;
	logic [NS_W-1:0] meas_s1;
	logic            last_s1;
	logic            adv_s1;

	scan_sum_t sum;
	logic      sum_valid;
	logic      sum_ready;

	// A non-last word only folds into the accumulators, so it never waits;
	// a last word waits for room in the interval pipeline.
	assign sum_valid = valid_s1 && last_s1;
	assign adv_s1    = valid_s1 && (!last_s1 || sum_ready);
	assign in_stall  = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ts_s1   <= point_timestamp;
			has_s1  <= has_point;
			meas_s1 <= meas_time;
			last_s1 <= last;
		end
	end

	// ------------------------------------------------------------------
	// Scan accumulators: earliest and latest usable stamp, usable flag, point seen.
	// A usable stamp is nonzero and fits in 63 bits, so 63-bit storage suffices;
	// the empty earliest value is all ones.
	// ------------------------------------------------------------------
	logic [NS_W-1:0] earliest_q, latest_q;
	logic            usable_q, seen_q;
	logic [NS_W-1:0] earliest_n, latest_n;
	logic            usable_n, seen_n;
	logic            stamp_usable;
	logic [NS_W-1:0] stamp;

	assign stamp        = ts_s1[NS_W-1:0];
	assign stamp_usable = (ts_s1 != '0) && !ts_s1[TS_W-1];

	always_comb begin
		earliest_n = earliest_q;
		latest_n   = latest_q;
		usable_n   = usable_q;
		seen_n     = seen_q;
		if (has_s1) begin
			seen_n = 1'b1;
			if (!stamp_usable) begin
				usable_n = 1'b0;
			end else begin
				if (stamp < earliest_q) earliest_n = stamp;
				if (stamp > latest_q)   latest_n   = stamp;
			end
		end
	end

	// Closed scan summary, including the last word's own point
	always_comb begin
		sum.earliest     = earliest_n;
		sum.latest       = latest_n;
		sum.latest_valid = latest_n != '0;
		sum.all_stamped  = seen_n && usable_n;
		sum.meas         = meas_s1;
	end

	// Fold the word in, or drop the scan back to empty once it is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_q <= '1;
			latest_q   <= '0;
			usable_q   <= 1'b1;
			seen_q     <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				earliest_q <= '1;
				latest_q   <= '0;
				usable_q   <= 1'b1;
				seen_q     <= 1'b0;
			end else begin
				earliest_q <= earliest_n;
				latest_q   <= latest_n;
				usable_q   <= usable_n;
				seen_q     <= seen_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 to 4: interval checks, fallback and offset
	// ------------------------------------------------------------------
	result_t res;
	logic    res_valid;
	logic    res_ready;

	lstn_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.sum_valid (sum_valid),
		.sum       (sum),
		.sum_ready (sum_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// ------------------------------------------------------------------
	// Output register: advance when empty or when the held word is taken
	// ------------------------------------------------------------------
	logic    out_valid_q;
	result_t out_q;

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_q.ok;
	assign span_start  = out_q.span_start;
	assign span_stop   = out_q.span_stop;
	assign quality     = out_q.quality;
	assign all_stamped = out_q.all_stamped;

`ifndef SYNTH
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && !sum_ready)
		else $error("input stalled without a blocked last word");

	a_scan_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> earliest_q == '1 && latest_q == '0 && usable_q && !seen_q)
		else $error("accumulators not cleared after last word");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> span_start == '0 && span_stop == '0 && !quality && !all_stamped)
		else $error("failed result carries nonzero fields");

	a_ok_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> span_stop >= span_start && span_start != '0)
		else $error("valid interval not ordered or not positive");
`endif

endmodule

>>> src/lstn_finish.sv
// Interval builder: three pipeline stages from a closed scan summary to a result word.
// Depends on lstn_pkg (cfg_t, scan_sum_t, result_t, anchor codes).
module lstn_finish (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lstn_pkg::cfg_t       cfg,
	input  logic                 sum_valid,
	input  lstn_pkg::scan_sum_t  sum,
	output logic                 sum_ready,
	output logic                 res_valid,
	output lstn_pkg::result_t    res,
	input  logic                 res_ready
);
	import lstn_pkg::*;

	// stage 2: closed scan summary
	logic            valid_s2;
	scan_sum_t       sum_s2;

	// stage 3: span check, anchor point, fallback interval
	logic                     valid_s3;
	logic [NS_W-1:0]          earliest_s3;
	logic [NS_W-1:0]          latest_s3;
	logic [NS_W-1:0]          anchor_s3;
	logic [NS_W-1:0]          meas_s3;
	logic                     span_ok_s3;
	logic signed [TS_W-1:0]   fb_begin_s3;
	logic [NS_W-1:0]          fb_end_s3;
	logic                     fb_ovf_s3;
	logic                     all_s3;

	// stage 4: selected interval before offset
	logic            valid_s4;
	logic            fail_s4;
	logic [NS_W-1:0] begin_s4;
	logic [NS_W-1:0] end_s4;
	logic            quality_s4;
	logic            all_s4;

	logic rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4    = !valid_s4 || res_ready;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign sum_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s2) valid_s2 <= sum_valid;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && sum_valid) sum_s2 <= sum;
	end

	// ---- stage 2 logic ----
	logic [NS_W-1:0]         span;
	logic [NS_W-1:0]         mid;
	logic [NS_W-1:0]         anchor;
	logic                    span_ok;
	logic signed [SUM_W-1:0] meas_w;
	logic signed [SUM_W-1:0] exp_w;
	logic signed [SUM_W-1:0] half_w;
	logic signed [SUM_W-1:0] fb_begin;
	logic signed [SUM_W-1:0] fb_end;

	assign span    = sum_s2.latest - sum_s2.earliest;
	assign mid     = sum_s2.earliest + (span >> 1);
	assign span_ok = sum_s2.latest_valid &&
		(span <= {{(NS_W-DUR_W){1'b0}}, cfg.max_duration});
	assign meas_w  = $signed({2'b00, sum_s2.meas});
	assign exp_w   = $signed({{(SUM_W-DUR_W){1'b0}}, cfg.expected_duration});
	assign half_w  = $signed({{(SUM_W-DUR_W+1){1'b0}}, cfg.expected_duration[DUR_W-1:1]});

	always_comb begin
		case (cfg.anchor_mode)
			ANCHOR_BEGIN: anchor = sum_s2.earliest;
			ANCHOR_MID:   anchor = mid;
			default:      anchor = sum_s2.latest;
		endcase
	end

	always_comb begin
		case (cfg.anchor_mode)
			ANCHOR_BEGIN: begin
				fb_begin = meas_w;
				fb_end   = meas_w + exp_w;
			end
			ANCHOR_MID: begin
				fb_begin = meas_w - half_w;
				fb_end   = fb_begin + exp_w;
			end
			default: begin
				fb_end   = meas_w;
				fb_begin = meas_w - exp_w;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			earliest_s3 <= sum_s2.earliest;
			latest_s3   <= sum_s2.latest;
			anchor_s3   <= anchor;
			meas_s3     <= sum_s2.meas;
			span_ok_s3  <= span_ok;
			fb_begin_s3 <= fb_begin[TS_W-1:0];
			fb_end_s3   <= fb_end[NS_W-1:0];
			fb_ovf_s3   <= fb_end > SUM_MAX;
			all_s3      <= sum_s2.all_stamped;
		end
	end

	// ---- stage 3 logic ----
	logic                   have_meas;
	logic [NS_W-1:0]        diff;
	logic                   pts_ok;
	logic                   dur_bad;
	logic signed [TS_W-1:0] begin_sel;
	logic [NS_W-1:0]        end_sel;
	logic                   fail_sel;

	assign have_meas = meas_s3 != '0;
	assign diff      = (anchor_s3 >= meas_s3) ? (anchor_s3 - meas_s3) : (meas_s3 - anchor_s3);
	assign pts_ok    = span_ok_s3 &&
		(!have_meas || (diff <= {{(NS_W-DUR_W){1'b0}}, cfg.max_duration}));
	assign dur_bad   = (cfg.max_duration == '0) || (cfg.expected_duration == '0) ||
		(cfg.expected_duration > cfg.max_duration);
	assign begin_sel = pts_ok ? $signed({1'b0, earliest_s3}) : fb_begin_s3;
	assign end_sel   = pts_ok ? latest_s3 : fb_end_s3;
	assign fail_sel  = dur_bad || (!pts_ok && (!have_meas || fb_ovf_s3)) ||
		(begin_sel <= 64'sd0);

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			fail_s4    <= fail_sel;
			begin_s4   <= begin_sel[NS_W-1:0];
			end_s4     <= end_sel;
			quality_s4 <= !pts_ok;
			all_s4     <= all_s3;
		end
	end

	// ---- stage 4 logic: static offset ----
	logic signed [SUM_W-1:0] off_w;
	logic signed [SUM_W-1:0] begin_sum;
	logic signed [SUM_W-1:0] end_sum;
	logic                    fail_fin;

	assign off_w     = $signed({{(SUM_W-OFF_W){cfg.static_offset[OFF_W-1]}}, cfg.static_offset});
	assign begin_sum = $signed({2'b00, begin_s4}) + off_w;
	assign end_sum   = $signed({2'b00, end_s4}) + off_w;
	assign fail_fin  = fail_s4 || (end_sum > SUM_MAX) || (begin_sum <= 65'sd0);

	assign res_valid       = valid_s4;
	assign res.ok          = !fail_fin;
	assign res.span_start  = fail_fin ? '0 : begin_sum[NS_W-1:0];
	assign res.span_stop   = fail_fin ? '0 : end_sum[NS_W-1:0];
	assign res.quality     = !fail_fin && quality_s4;
	assign res.all_stamped = !fail_fin && all_s4;

`ifndef SYNTH
	a_sum_enters: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_ready |=> valid_s2)
		else $error("accepted scan summary did not reach stage 2");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && span_ok_s3 |-> latest_s3 >= earliest_s3)
		else $error("point span accepted with latest below earliest");

	a_interval_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !fail_s4 |-> end_s4 >= begin_s4 && begin_s4 != '0)
		else $error("selected interval not ordered or not positive");
`endif

endmodule

>>> tb/sv/lidar_scan_time_normalizer_unit_test.sv
// Self-checking bench for lidar_scan_time_normalizer_unit: streams scans of point stamps,
// predicts every scan interval in a local model and compares each result word field by field.
// Depends on lstn_pkg (widths, register indexes, anchor codes, result_t) and the unit itself.
module lidar_scan_time_normalizer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lstn_pkg::*;

	localparam int          RESET_CYCLES    = 8;
	localparam int          SETTLE_CYCLES   = 8;     // extra drain wait after the expected words are back
	localparam int          HOLD_CYCLES     = 400;   // long receiver hold-off for back-pressure
	localparam int          WATCHDOG_LIMIT  = 3000;  // quiet cycles before the run is abandoned
	localparam int          ITEMS_PER_PHASE = 75;
	localparam int          PRESSURE_SCANS  = 60;
	localparam logic [63:0] TS_TOP          = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint      TIME_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;

	// One input word as the driver presents it
	typedef struct {
		logic [TS_W-1:0] ts;
		logic            has;
		logic [NS_W-1:0] meas;
		logic            last;
	} scan_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                wr_en = 1'b0;
	logic [IDX_W-1:0]    wr_index = '0;
	logic [DATA_W-1:0]   wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [TS_W-1:0]     point_timestamp = '0;
	logic                has_point = 1'b0;
	logic [NS_W-1:0]     meas_time = '0;
	logic                last = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                ok;
	logic [NS_W-1:0]     span_start;
	logic [NS_W-1:0]     span_stop;
	logic                quality;
	logic                all_stamped;

	lidar_scan_time_normalizer_unit DUT (.*);

	always #5 clk = ~clk;

	// Bench-side copy of the configuration and of the scan accumulators
	cfg_t        shadow_cfg = '{MAX_DURATION_RST, EXP_DURATION_RST, ANCHOR_MODE_RST, OFFSET_RST};
	logic [63:0] acc_earliest = '1;
	logic [63:0] acc_latest = '0;
	bit          acc_usable = 1'b1;
	bit          acc_seen = 1'b0;

	scan_word_t  pending_words[$];
	result_t     expected_intervals[$];
	scan_word_t  cur_word;

	int          source_level = 0;   // 0: no gaps, 1: sparse gaps, 2: a drawn gap, which may be empty, after every word
	int          sink_level = 0;
	int unsigned src_wait = 0;
	int unsigned sink_wait = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned error_count = 0;
	int unsigned words_sent = 0;
	int unsigned results_seen = 0;
	int unsigned settings_run = 0;
	int unsigned queued_items = 0;

	function automatic int unsigned draw_wait(int level);
		case (level)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// Build the interval for the scan that closes with this measurement time.
	// Any failed check yields an all-zero word.
	function automatic result_t close_scan(logic [NS_W-1:0] meas);
		result_t     res;
		result_t     fail;
		longint      maxd, expd, ms, b, e, off;
		logic [63:0] span, a, gap, meas64, maxd64;
		bit          have_meas, pts_ok, fallback;
		fail = '0;
		res = '0;
		maxd64 = {32'd0, shadow_cfg.max_duration};
		maxd = longint'(maxd64);
		expd = longint'({32'd0, shadow_cfg.expected_duration});
		meas64 = {1'b0, meas};
		ms = longint'(meas64);
		have_meas = meas != '0;
		if (maxd == 0 || expd == 0 || expd > maxd)
			return fail;

		span = acc_latest - acc_earliest;
		pts_ok = acc_latest != '0 && span <= maxd64;
		if (pts_ok && have_meas) begin
			case (shadow_cfg.anchor_mode)
				ANCHOR_BEGIN: a = acc_earliest;
				ANCHOR_MID:   a = acc_earliest + span / 2;
				default:      a = acc_latest;
			endcase
			gap = (a > meas64) ? a - meas64 : meas64 - a;
			pts_ok = gap <= maxd64;
		end

		if (pts_ok) begin
			b = longint'(acc_earliest);
			e = longint'(acc_latest);
			fallback = 1'b0;
		end else begin
			// fall back to measurement time and nominal duration
			if (!have_meas)
				return fail;
			case (shadow_cfg.anchor_mode)
				ANCHOR_BEGIN: begin
					b = ms;
					if (ms > TIME_MAX - expd)
						return fail;
					e = ms + expd;
				end
				ANCHOR_MID: begin
					b = ms - expd / 2;
					if (b > TIME_MAX - expd)
						return fail;
					e = b + expd;
				end
				default: begin
					e = ms;
					b = ms - expd;
				end
			endcase
			fallback = 1'b1;
		end

		if (b <= 0 || e < b || e - b > maxd)
			return fail;
		off = longint'({{16{shadow_cfg.static_offset[OFF_W-1]}}, shadow_cfg.static_offset});
		if (off > 0 && e > TIME_MAX - off)
			return fail;
		b += off;
		e += off;
		if (b <= 0)
			return fail;
		res.ok = 1'b1;
		res.span_start = b[NS_W-1:0];
		res.span_stop = e[NS_W-1:0];
		res.quality = fallback;
		res.all_stamped = acc_seen && acc_usable;
		return res;
	endfunction

	// Fold one accepted word into the accumulators; a last word closes the scan.
	task automatic accumulate_stamp(scan_word_t w);
		if (w.has) begin
			acc_seen = 1'b1;
			if (w.ts == '0 || w.ts > TS_TOP) begin
				acc_usable = 1'b0;
			end else begin
				if (w.ts < acc_earliest)
					acc_earliest = w.ts;
				if (w.ts > acc_latest)
					acc_latest = w.ts;
			end
		end
		if (w.last) begin
			expected_intervals.push_back(close_scan(w.meas));
			acc_earliest = '1;
			acc_latest = '0;
			acc_usable = 1'b1;
			acc_seen = 1'b0;
		end
	endtask

	task automatic push_word(logic [63:0] ts, logic has, logic [NS_W-1:0] meas, logic lst);
		scan_word_t w;
		w.ts = ts;
		w.has = has;
		w.meas = meas;
		w.last = lst;
		pending_words.push_back(w);
		if (has || lst)
			queued_items++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Queue one scan: mostly well-formed spans around the configured limits, with bad
	// stamps, ignored filler words and odd measurement times mixed in.
	task automatic queue_scan();
		int unsigned npts, imin, imax, pick;
		logic [63:0] span, base, stamp, anchor_pt;
		logic [NS_W-1:0] meas;
		longint      delta;
		bit          close_empty;
		npts = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
		close_empty = npts == 0 || $urandom_range(0, 3) == 0;

		pick = $urandom_range(0, 9);
		if (pick < 7)
			span = 64'($urandom_range(0, shadow_cfg.max_duration));
		else if (pick < 9)
			span = 64'(shadow_cfg.max_duration) + 64'($urandom_range(1, 1000));
		else
			span = 64'($urandom);

		pick = $urandom_range(0, 9);
		base = rand64() & TS_TOP;
		if (pick == 8)
			base = 64'($urandom_range(1, 200000));
		else if (pick == 9)
			base = TS_TOP - span - 64'($urandom_range(0, 1000));
		if (base > TS_TOP - span)
			base = TS_TOP - span;
		if (base == '0)
			base = 64'd1;

		case (shadow_cfg.anchor_mode)
			ANCHOR_BEGIN: anchor_pt = base;
			ANCHOR_MID:   anchor_pt = base + span / 2;
			default:      anchor_pt = base + span;
		endcase
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			meas = '0;
		end else if (pick == 1) begin
			stamp = rand64();
			meas = stamp[NS_W-1:0];
		end else if (pick == 2) begin
			stamp = TS_TOP - 64'($urandom_range(0, shadow_cfg.expected_duration));
			meas = stamp[NS_W-1:0];
		end else begin
			if (pick < 8)
				delta = longint'($urandom_range(0, shadow_cfg.max_duration));
			else
				delta = longint'(shadow_cfg.max_duration) + longint'($urandom_range(1, 1 << 20));
			if ($urandom_range(0, 1) == 0)
				delta = -delta;
			stamp = anchor_pt + 64'(delta);
			meas = stamp[NS_W-1:0];
		end

		imin = (npts > 0) ? $urandom_range(0, npts - 1) : 0;
		imax = (npts > 1) ? (imin + $urandom_range(1, npts - 1)) % npts : imin;
		for (int i = 0; i < int'(npts); i++) begin
			// drop an ignored filler word in now and then
			if ($urandom_range(0, 7) == 0)
				push_word(rand64(), 1'b0, rand64(), 1'b0);
			if (i == int'(imin))
				stamp = base;
			else if (i == int'(imax))
				stamp = base + span;
			else
				stamp = base + rand64() % (span + 64'd1);
			if ($urandom_range(0, 15) == 0)
				stamp = $urandom_range(0, 1) ? 64'd0 : (rand64() | 64'h8000_0000_0000_0000);
			if (i == int'(npts) - 1 && !close_empty)
				push_word(stamp, 1'b1, meas, 1'b1);
			else
				push_word(stamp, 1'b1, rand64(), 1'b0);
		end
		if (close_empty)
			push_word(rand64(), 1'b0, meas, 1'b1);
	endtask

	// Wait until every queued word is accepted and every expected word has come back,
	// then let the pipeline drain a little further.
	task automatic settle_pipeline();
		while (pending_words.size() != 0 || in_valid || expected_intervals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_MAX_DURATION:      shadow_cfg.max_duration = val[DUR_W-1:0];
			REG_EXPECTED_DURATION: shadow_cfg.expected_duration = val[DUR_W-1:0];
			REG_ANCHOR_MODE:       shadow_cfg.anchor_mode = val[MODE_W-1:0];
			REG_STATIC_OFFSET:     shadow_cfg.static_offset = val[OFF_W-1:0];
			default: ;
		endcase
	endtask

	// Reprogram all four registers while idle, then queue a phase of random scans
	task automatic run_phase(logic [31:0] max_ns, logic [31:0] exp_ns, logic [1:0] mode,
			logic [47:0] off_ns, int src_lvl, int sink_lvl);
		logic [15:0] junk;
		logic [29:0] junk_wide;
		settle_pipeline();
		junk = 16'($urandom);
		junk_wide = 30'($urandom);
		// upper write-data bits beyond a register's width are don't-care; toggle them
		write_reg(REG_MAX_DURATION, {junk, max_ns});
		write_reg(REG_EXPECTED_DURATION, {~junk, exp_ns});
		write_reg(REG_ANCHOR_MODE, {junk, junk_wide, mode});
		write_reg(REG_STATIC_OFFSET, off_ns);
		source_level = src_lvl;
		sink_level = sink_lvl;
		settings_run++;
		queued_items = 0;
		while (queued_items < ITEMS_PER_PHASE)
			queue_scan();
	endtask

	task automatic check_field(string name, logic [NS_W-1:0] want, logic [NS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// Driver: present the oldest pending word, hold it while stalled, and insert the drawn gap
	// after each accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				accumulate_stamp(cur_word);
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (src_wait > 0) begin
					src_wait--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					cur_word = pending_words.pop_front();
					point_timestamp <= cur_word.ts;
					has_point <= cur_word.has;
					meas_time <= cur_word.meas;
					last <= cur_word.last;
					in_valid <= 1'b1;
					src_wait = draw_wait(source_level);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result word with the oldest expectation, then decide the
	// stall for the next cycle. A hold-off request overrides the per-word draw.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_intervals.size() == 0) begin
					$error("result word with nothing expected: ok=%0d start=%0h stop=%0h",
						ok, span_start, span_stop);
					error_count++;
				end else begin
					want = expected_intervals.pop_front();
					check_field("ok", want.ok, ok);
					check_field("span_start", want.span_start, span_start);
					check_field("span_stop", want.span_stop, span_stop);
					check_field("quality", want.quality, quality);
					check_field("all_stamped", want.all_stamped, all_stamped);
				end
				sink_wait = draw_wait(sink_level);
			end
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (sink_wait > 0) begin
				sink_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: abandon the run when no handshake and no register write happen for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$error("no handshake for %0d cycles", WATCHDOG_LIMIT);
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [63:0] r64;
		logic [31:0] rmax;
		logic [31:0] rexp;
		logic [47:0] roff;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed scans under the reset configuration (2e8 max, 1e8 nominal, anchor at end)
		// normal two-point scan, measurement on the latest stamp
		push_word(64'd1_000_000_000_000, 1'b1, rand64(), 1'b0);
		push_word(64'd1_000_100_000_000, 1'b1, 63'd1_000_100_000_000, 1'b1);
		// empty scan with a measurement: fallback interval, nothing stamped
		push_word(64'd0, 1'b0, 63'd5_000_000_000, 1'b1);
		// empty scan without a measurement: fails
		push_word('1, 1'b0, 63'd0, 1'b1);
		// zero, all-ones and just-above-signed stamps, then the largest usable stamp
		push_word(64'd0, 1'b1, '1, 1'b0);
		push_word('1, 1'b1, '0, 1'b0);
		push_word(64'h8000_0000_0000_0000, 1'b1, '0, 1'b0);
		push_word(TS_TOP, 1'b1, '1, 1'b1);
		// span over the limit and no measurement
		push_word(64'd1_000_000_000, 1'b1, '0, 1'b0);
		push_word(64'd1_300_000_000, 1'b1, 63'd0, 1'b1);
		// anchor far from the measurement: fallback with every point stamped
		push_word(64'd1_000_000_000, 1'b1, '0, 1'b0);
		push_word(64'd1_050_000_000, 1'b1, 63'd5_000_000_000, 1'b1);
		// fallback that would begin before zero
		push_word(64'd0, 1'b0, 63'd50_000_000, 1'b1);
		// points closed by an empty last word
		push_word(64'd2_000_000_000, 1'b1, '0, 1'b0);
		push_word('0, 1'b0, 63'd2_000_000_000, 1'b1);
		// single point at the smallest usable stamp
		push_word(64'd1, 1'b1, 63'd0, 1'b1);
		// largest measurement time on an empty scan
		push_word('0, 1'b0, '1, 1'b1);

		// Fixed settings, the extremes among them
		run_phase(32'd200_000_000, 32'd100_000_000, ANCHOR_BEGIN, 48'd0, 0, 0);
		run_phase(32'd200_000_000, 32'd100_000_000, ANCHOR_MID, 48'd0, 1, 1);
		run_phase(32'd200_000_000, 32'd100_000_000, 2'd3, 48'd0, 2, 0);
		run_phase(32'd0, 32'd100_000_000, ANCHOR_END, 48'd0, 0, 2);
		run_phase(32'd200_000_000, 32'd0, ANCHOR_BEGIN, 48'd0, 1, 0);
		run_phase(32'd100_000_000, 32'd200_000_000, ANCHOR_MID, 48'd0, 0, 1);

		// Back-pressure: the receiver holds off while single-point scans keep coming
		settle_pipeline();
		source_level = 0;
		sink_level = 0;
		hold_requests++;
		for (int i = 0; i < PRESSURE_SCANS; i++) begin
			r64 = rand64() & TS_TOP;
			push_word(r64 | 64'd1, 1'b1, r64[NS_W-1:0], 1'b1);
		end

		run_phase('1, '1, ANCHOR_MID, 48'h7FFF_FFFF_FFFF, 2, 2);
		run_phase('1, 32'd1, ANCHOR_BEGIN, 48'h8000_0000_0000, 1, 2);
		run_phase(32'd5000, 32'd2000, ANCHOR_MID, -48'sd3000, 2, 1);
		run_phase(32'd1, 32'd1, ANCHOR_END, 48'd1, 0, 0);

		// Random settings
		for (int p = 0; p < 6; p++) begin
			rmax = $urandom_range(0, 1) ? 32'($urandom_range(1, 1_000_000)) : $urandom;
			rexp = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, rmax)) : $urandom;
			r64 = rand64();
			roff = $urandom_range(0, 1) ? r64[47:0]
				: 48'($signed(64'(longint'($urandom_range(0, 2_000_000)) - 64'sd1_000_000)));
			run_phase(rmax, rexp, 2'($urandom_range(0, 3)), roff,
				$urandom_range(0, 2), $urandom_range(0, 2));
		end

		settle_pipeline();
		$display("Sent %0d input words, checked %0d scan results over %0d register settings,",
			words_sent, results_seen, settings_run);
		$display("including one long receiver hold-off with the input backed up.");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
